// File: hdl/rotate_about_center_mapper_defines.svh
// Assertion macros for the rotate-about-center coordinate mapper.
// Included by rcm_core, which checks its own pipeline behavior.
// Depends on nothing; compiles to empty macros when SYNTHESIS is defined.
`ifndef ROTATE_ABOUT_CENTER_MAPPER_DEFINES_SVH
`define ROTATE_ABOUT_CENTER_MAPPER_DEFINES_SVH
`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define RCM_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rcm: same-cycle check failed");
// Consequent must hold in the cycle after the antecedent.
`define RCM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rcm: next-cycle check failed");
`else
`define RCM_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define RCM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: hdl/rcm_pkg.sv
// Shared types and constants for the rotate-about-center coordinate mapper.
// Used by rcm_core and rotate_about_center_mapper; depends on nothing.
package rcm_pkg;

    // Operation selected by one input item.
    typedef enum logic {
        MODE_PIX = 1'b0,
        MODE_BOX = 1'b1
    } t_mode;

    // Configuration register indexes (byte address is four times the index).
    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_COS    = 2'd2,
        REG_SIN    = 2'd3
    } t_reg_idx;

    localparam int APB_DW = 32;
    localparam int APB_AW = 4;

endpackage

// File: hdl/rcm_core.sv
// Five-stage datapath of the rotate-about-center mapper: offsets, products,
// corner sums, min/max and final rounding with saturation.
// Depends on rcm_pkg and rotate_about_center_mapper_defines.svh.
`include "rotate_about_center_mapper_defines.svh"

module rcm_core #(
    parameter int MAX_DIM        = 4096,
    parameter int COEF_FRAC_BITS = 14,
    parameter int OUT_FRAC_BITS  = 8,
    localparam int PIX_W = $clog2(MAX_DIM),
    localparam int DIM_W = PIX_W + 1,
    localparam int CW    = COEF_FRAC_BITS + 2,
    localparam longint SRC_HI = longint'(5 * MAX_DIM / 2) * (longint'(1) << OUT_FRAC_BITS),
    localparam longint SRC_LO = -(longint'(3 * MAX_DIM / 2) * (longint'(1) << OUT_FRAC_BITS)),
    localparam int SRC_W  = $clog2(SRC_HI + 1) + 1,
    localparam int BOX_HI = 5 * MAX_DIM / 2 + 1,
    localparam int BOX_LO = -(3 * MAX_DIM / 2) - 1,
    localparam int BOX_W  = $clog2(BOX_HI + 1) + 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration, stable while items are in flight
    input  logic [DIM_W-1:0]        i_cfg_width,
    input  logic [DIM_W-1:0]        i_cfg_height,
    input  logic signed [CW-1:0]    i_cfg_cos,
    input  logic signed [CW-1:0]    i_cfg_sin,
    // input channel
    input  logic                    i_valid,
    output logic                    o_ready,
    input  rcm_pkg::t_mode          i_mode,
    input  logic [PIX_W-1:0]        i_pix_x,
    input  logic [PIX_W-1:0]        i_pix_y,
    input  logic [DIM_W-1:0]        i_rect_xmin,
    input  logic [DIM_W-1:0]        i_rect_ymin,
    input  logic [DIM_W-1:0]        i_rect_xmax,
    input  logic [DIM_W-1:0]        i_rect_ymax,
    // result channel
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [SRC_W-1:0] o_src_x_fx,
    output logic signed [SRC_W-1:0] o_src_y_fx,
    output logic signed [BOX_W-1:0] o_box_xmin,
    output logic signed [BOX_W-1:0] o_box_xmax,
    output logic signed [BOX_W-1:0] o_box_ymin,
    output logic signed [BOX_W-1:0] o_box_ymax
);
    import rcm_pkg::*;

    localparam int NSTG   = 5;
    localparam int DX_W   = DIM_W + 2;
    localparam int PROD_W = CW + DX_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int SHR    = COEF_FRAC_BITS + 1;
    localparam int UP     = (OUT_FRAC_BITS > SHR) ? OUT_FRAC_BITS - SHR : 0;
    localparam int DN     = (OUT_FRAC_BITS > SHR) ? 0 : SHR - OUT_FRAC_BITS;
    localparam int SH_W   = SUM_W + UP;
    localparam int BX_W   = SUM_W + 1;

    localparam logic signed [SH_W-1:0] SRC_HI_V = SH_W'(SRC_HI);
    localparam logic signed [SH_W-1:0] SRC_LO_V = SH_W'(SRC_LO);
    localparam logic signed [BX_W-1:0] BOX_HI_V = BX_W'(BOX_HI);
    localparam logic signed [BX_W-1:0] BOX_LO_V = BX_W'(BOX_LO);

    // Doubled offset from the center: 2*p - d, exact for odd sizes.
    function automatic logic signed [DX_W-1:0] f_dbl_off(input logic [DIM_W-1:0] p,
                                                         input logic [DIM_W-1:0] d);
        return $signed({1'b0, p, 1'b0}) - $signed({2'b00, d});
    endfunction

    function automatic logic signed [SUM_W-1:0] f_min(input logic signed [SUM_W-1:0] a,
                                                      input logic signed [SUM_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic signed [SUM_W-1:0] f_max(input logic signed [SUM_W-1:0] a,
                                                      input logic signed [SUM_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

    // Pipeline flow control: a stage loads when it is empty or its item moves on,
    // which is the case unless it and every stage after it are full and stalled.
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_en;

    always_comb begin
        logic v_full;
        v_full = 1'b1;
        for (int k = NSTG - 1; k >= 0; k--) begin
            v_full  = v_full && r_vld[k];
            w_en[k] = i_ready || !v_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_vld[NSTG-1];

    // Stage 1: lane coordinates as doubled center offsets.
    // Lane a carries the pixel in pixel mode and the min edges in box mode.
    logic [DIM_W-1:0]        n_xa, n_ya;
    logic signed [DX_W-1:0]  r1_dxa, r1_dxb, r1_dya, r1_dyb;
    t_mode                   r1_mode;

    always_comb begin
        if (i_mode == MODE_BOX) begin
            n_xa = i_rect_xmin;
            n_ya = i_rect_ymin;
        end else begin
            n_xa = {1'b0, i_pix_x};
            n_ya = {1'b0, i_pix_y};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r1_mode <= i_mode;
            r1_dxa  <= f_dbl_off(n_xa, i_cfg_width);
            r1_dxb  <= f_dbl_off(i_rect_xmax, i_cfg_width);
            r1_dya  <= f_dbl_off(n_ya, i_cfg_height);
            r1_dyb  <= f_dbl_off(i_rect_ymax, i_cfg_height);
        end
    end

    // Stage 2: the eight coefficient products.
    logic signed [PROD_W-1:0] r2_cx [2];
    logic signed [PROD_W-1:0] r2_sx [2];
    logic signed [PROD_W-1:0] r2_cy [2];
    logic signed [PROD_W-1:0] r2_sy [2];
    t_mode                    r2_mode;

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r2_mode  <= r1_mode;
            r2_cx[0] <= i_cfg_cos * r1_dxa;
            r2_cx[1] <= i_cfg_cos * r1_dxb;
            r2_sx[0] <= i_cfg_sin * r1_dxa;
            r2_sx[1] <= i_cfg_sin * r1_dxb;
            r2_cy[0] <= i_cfg_cos * r1_dya;
            r2_cy[1] <= i_cfg_cos * r1_dyb;
            r2_sy[0] <= i_cfg_sin * r1_dya;
            r2_sy[1] <= i_cfg_sin * r1_dyb;
        end
    end

    // Stage 3: exact rotated corners in units of 2^-SHR pixel.
    // Corner index is {y lane, x lane}; corner 0 is the pixel in pixel mode.
    logic signed [SUM_W-1:0] w_wterm, w_hterm;
    logic signed [SUM_W-1:0] r3_rx [4];
    logic signed [SUM_W-1:0] r3_ry [4];
    t_mode                   r3_mode;

    assign w_wterm = SUM_W'($signed({1'b0, i_cfg_width, {COEF_FRAC_BITS{1'b0}}}));
    assign w_hterm = SUM_W'($signed({1'b0, i_cfg_height, {COEF_FRAC_BITS{1'b0}}}));

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r3_mode <= r2_mode;
            for (int c = 0; c < 4; c++) begin
                r3_rx[c] <= w_wterm + r2_cx[c % 2] + r2_sy[c / 2];
                r3_ry[c] <= w_hterm - r2_sx[c % 2] + r2_cy[c / 2];
            end
        end
    end

    // Stage 4: extremes over the four corners; the min slots hold corner 0
    // in pixel mode.
    logic signed [SUM_W-1:0] r4_mnx, r4_mxx, r4_mny, r4_mxy;
    t_mode                   r4_mode;

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r4_mode <= r3_mode;
            r4_mxx  <= f_max(f_max(r3_rx[0], r3_rx[1]), f_max(r3_rx[2], r3_rx[3]));
            r4_mxy  <= f_max(f_max(r3_ry[0], r3_ry[1]), f_max(r3_ry[2], r3_ry[3]));
            if (r3_mode == MODE_BOX) begin
                r4_mnx <= f_min(f_min(r3_rx[0], r3_rx[1]), f_min(r3_rx[2], r3_rx[3]));
                r4_mny <= f_min(f_min(r3_ry[0], r3_ry[1]), f_min(r3_ry[2], r3_ry[3]));
            end else begin
                r4_mnx <= r3_rx[0];
                r4_mny <= r3_ry[0];
            end
        end
    end

    // Stage 5: rounding toward minus infinity, floor/ceil and saturation.
    logic signed [SH_W-1:0] w_sx, w_sy, w_sx_sat, w_sy_sat;
    logic signed [BX_W-1:0] w_bxmin, w_bxmax, w_bymin, w_bymax;
    logic signed [BX_W-1:0] w_bxmin_s, w_bxmax_s, w_bymin_s, w_bymax_s;
    logic signed [BX_W-1:0] w_rnd;

    assign w_rnd = BX_W'($signed({1'b0, {SHR{1'b1}}}));

    always_comb begin
        w_sx = (SH_W'(r4_mnx) >>> DN) <<< UP;
        w_sy = (SH_W'(r4_mny) >>> DN) <<< UP;
        w_sx_sat = (w_sx > SRC_HI_V) ? SRC_HI_V : ((w_sx < SRC_LO_V) ? SRC_LO_V : w_sx);
        w_sy_sat = (w_sy > SRC_HI_V) ? SRC_HI_V : ((w_sy < SRC_LO_V) ? SRC_LO_V : w_sy);

        w_bxmin = (BX_W'(r4_mnx) >>> SHR) - BX_W'(1);
        w_bymin = (BX_W'(r4_mny) >>> SHR) - BX_W'(1);
        w_bxmax = ((BX_W'(r4_mxx) + w_rnd) >>> SHR) + BX_W'(1);
        w_bymax = ((BX_W'(r4_mxy) + w_rnd) >>> SHR) + BX_W'(1);

        w_bxmin_s = (w_bxmin > BOX_HI_V) ? BOX_HI_V
                  : ((w_bxmin < BOX_LO_V) ? BOX_LO_V : w_bxmin);
        w_bymin_s = (w_bymin > BOX_HI_V) ? BOX_HI_V
                  : ((w_bymin < BOX_LO_V) ? BOX_LO_V : w_bymin);
        w_bxmax_s = (w_bxmax > BOX_HI_V) ? BOX_HI_V
                  : ((w_bxmax < BOX_LO_V) ? BOX_LO_V : w_bxmax);
        w_bymax_s = (w_bymax > BOX_HI_V) ? BOX_HI_V
                  : ((w_bymax < BOX_LO_V) ? BOX_LO_V : w_bymax);
    end

    t_mode r5_mode;

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r5_mode <= r4_mode;
            if (r4_mode == MODE_BOX) begin
                o_src_x_fx <= '0;
                o_src_y_fx <= '0;
                o_box_xmin <= BOX_W'(w_bxmin_s);
                o_box_xmax <= BOX_W'(w_bxmax_s);
                o_box_ymin <= BOX_W'(w_bymin_s);
                o_box_ymax <= BOX_W'(w_bymax_s);
            end else begin
                o_src_x_fx <= SRC_W'(w_sx_sat);
                o_src_y_fx <= SRC_W'(w_sy_sat);
                o_box_xmin <= '0;
                o_box_xmax <= '0;
                o_box_ymin <= '0;
                o_box_ymax <= '0;
            end
        end
    end

    // Result properties checked below.
    logic w_box_zero;
    logic w_box_ordered;

    assign w_box_zero    = (o_box_xmin == '0) && (o_box_xmax == '0)
                        && (o_box_ymin == '0) && (o_box_ymax == '0);
    assign w_box_ordered = (o_box_xmin <= o_box_xmax) && (o_box_ymin <= o_box_ymax)
                        && (o_src_x_fx == '0);

    // A full pipeline is the only reason to refuse an item.
    `RCM_ASSERT_SAME(a_ready_full, i_clk, i_rst_n, !o_ready, (&r_vld))
    // A stage that holds an item it cannot pass on keeps it.
    `RCM_ASSERT_NEXT(a_stage_hold, i_clk, i_rst_n, r_vld[3] && !w_en[4], r_vld[3])
    // Pixel results leave the box fields at zero.
    `RCM_ASSERT_SAME(a_pix_zero, i_clk, i_rst_n, o_valid && r5_mode == MODE_PIX, w_box_zero)
    // A source box is never inverted.
    `RCM_ASSERT_SAME(a_box_order, i_clk, i_rst_n, o_valid && r5_mode == MODE_BOX, w_box_ordered)

endmodule

// File: hdl/rotate_about_center_mapper.sv
// Top level of the rotate-about-center coordinate mapper: APB register
// file for size and rotation coefficients, plus the rcm_core datapath.
// Depends on rcm_pkg and rcm_core.
//
// Usage: the block maps destination coordinates of an image rotated about
// its center (width/2, height/2) back to source coordinates. Each input
// item carries a mode. In pixel mode (pix_x, pix_y) becomes a signed source
// position with OUT_FRAC_BITS fraction bits, rounded toward minus infinity.
// In box mode the four corners of the rectangle are rotated and the result
// is the floor of the minima minus one and the ceiling of the maxima plus
// one, per axis. Both result forms are saturated; unused fields read zero.
// Both channels use valid/ready. An item passes through five registers
// (offsets, multipliers, corner adders, min/max compare, rounding/saturation),
// the first loaded at the accepting edge. One item can be accepted on every
// clock while results flow on, so the sustained rate is then one item per
// cycle. When the receiver stalls, results stay in the output register and
// earlier stages keep filling; ready drops only once all five stages hold
// items. Reset (synchronous, active low) empties the pipeline and restores
// width and height to one, cosine to 1.0 and sine to 0.
// Registers are to be written over APB only while the block is idle; the
// block itself does not enforce this. pready is always high.
module rotate_about_center_mapper #(
    parameter int MAX_DIM        = 4096,
    parameter int COEF_FRAC_BITS = 14,
    parameter int OUT_FRAC_BITS  = 8,
    localparam int PIX_W = $clog2(MAX_DIM),
    localparam int DIM_W = PIX_W + 1,
    localparam int CW    = COEF_FRAC_BITS + 2,
    localparam longint SRC_HI = longint'(5 * MAX_DIM / 2) * (longint'(1) << OUT_FRAC_BITS),
    localparam int SRC_W  = $clog2(SRC_HI + 1) + 1,
    localparam int BOX_HI = 5 * MAX_DIM / 2 + 1,
    localparam int BOX_W  = $clog2(BOX_HI + 1) + 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // APB configuration port
    input  logic                         i_psel,
    input  logic                         i_penable,
    input  logic                         i_pwrite,
    input  logic [rcm_pkg::APB_AW-1:0]   i_paddr,
    input  logic [rcm_pkg::APB_DW-1:0]   i_pwdata,
    output logic [rcm_pkg::APB_DW-1:0]   o_prdata,
    output logic                         o_pready,
    // input item channel
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_mode,
    input  logic [PIX_W-1:0]             i_pix_x,
    input  logic [PIX_W-1:0]             i_pix_y,
    input  logic [DIM_W-1:0]             i_rect_xmin,
    input  logic [DIM_W-1:0]             i_rect_ymin,
    input  logic [DIM_W-1:0]             i_rect_xmax,
    input  logic [DIM_W-1:0]             i_rect_ymax,
    // result item channel
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [SRC_W-1:0]      o_src_x_fx,
    output logic signed [SRC_W-1:0]      o_src_y_fx,
    output logic signed [BOX_W-1:0]      o_box_xmin,
    output logic signed [BOX_W-1:0]      o_box_xmax,
    output logic signed [BOX_W-1:0]      o_box_ymin,
    output logic signed [BOX_W-1:0]      o_box_ymax
);
    import rcm_pkg::*;

    // Configuration registers.
    logic [DIM_W-1:0]     r_width;
    logic [DIM_W-1:0]     r_height;
    logic signed [CW-1:0] r_cos;
    logic signed [CW-1:0] r_sin;

    logic     w_wr;
    t_reg_idx w_idx;

    assign o_pready = 1'b1;
    assign w_wr     = i_psel && i_penable && i_pwrite && o_pready;
    // Registers sit on 32-bit word boundaries; the low address bits are ignored.
    assign w_idx    = t_reg_idx'(i_paddr[APB_AW-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_W'(1);
            r_height <= DIM_W'(1);
            r_cos    <= CW'(1) << COEF_FRAC_BITS;
            r_sin    <= '0;
        end else if (w_wr) begin
            case (w_idx)
                REG_WIDTH:  r_width  <= i_pwdata[DIM_W-1:0];
                REG_HEIGHT: r_height <= i_pwdata[DIM_W-1:0];
                REG_COS:    r_cos    <= i_pwdata[CW-1:0];
                REG_SIN:    r_sin    <= i_pwdata[CW-1:0];
                default:    ;
            endcase
        end
    end

    // Read data: sizes are zero-extended, coefficients sign-extended.
    always_comb begin
        case (w_idx)
            REG_WIDTH:  o_prdata = {{(APB_DW - DIM_W){1'b0}}, r_width};
            REG_HEIGHT: o_prdata = {{(APB_DW - DIM_W){1'b0}}, r_height};
            REG_COS:    o_prdata = {{(APB_DW - CW){r_cos[CW-1]}}, r_cos};
            REG_SIN:    o_prdata = {{(APB_DW - CW){r_sin[CW-1]}}, r_sin};
            default:    o_prdata = '0;
        endcase
    end

    // The whole mapping runs in the five-stage core.
    rcm_core #(
        .MAX_DIM        (MAX_DIM),
        .COEF_FRAC_BITS (COEF_FRAC_BITS),
        .OUT_FRAC_BITS  (OUT_FRAC_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_width  (r_width),
        .i_cfg_height (r_height),
        .i_cfg_cos    (r_cos),
        .i_cfg_sin    (r_sin),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_mode       (t_mode'(i_mode)),
        .i_pix_x      (i_pix_x),
        .i_pix_y      (i_pix_y),
        .i_rect_xmin  (i_rect_xmin),
        .i_rect_ymin  (i_rect_ymin),
        .i_rect_xmax  (i_rect_xmax),
        .i_rect_ymax  (i_rect_ymax),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_src_x_fx   (o_src_x_fx),
        .o_src_y_fx   (o_src_y_fx),
        .o_box_xmin   (o_box_xmin),
        .o_box_xmax   (o_box_xmax),
        .o_box_ymin   (o_box_ymin),
        .o_box_ymax   (o_box_ymax)
    );

endmodule
